@@ design/assert_macros.svh @@
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FAL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fal checker: property failed");

// next-cycle implication, sampled on clk, off during reset
`define FAL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fal checker: property failed");

`endif

@@ design/fal_pkg.sv @@
// types and constants of the fire alarm level controller
`default_nettype none

package fal_pkg;

	localparam int TEMP_W  = 12;
	localparam int LEVEL_W = 3;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [LEVEL_W-1:0] level_t;

	// alarm levels
	localparam level_t LEVEL_IDLE = 3'd0;
	localparam level_t LEVEL_WARN = 3'd2;
	localparam level_t LEVEL_FIRE = 3'd4;

	// register indexes
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_THRESHOLD  = 1'b0;
	localparam reg_idx_t REG_FAULT_TEMP = 1'b1;

	// register reset values, 0.1 degree units
	localparam temp_t THRESHOLD_RESET  = 12'sd800;
	localparam temp_t FAULT_TEMP_RESET = 12'sd300;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_ABS,
		ST_DIV,
		ST_NEG,
		ST_DONE
	} state_t;

	typedef struct packed {
		temp_t temp_one;
		temp_t temp_two;
		logic  smoke_detected;
		logic  therm_fault;
		logic  smoke_offline;
		logic  supply_fault;
		logic  press_fault;
		logic  ext_alarm_active;
		logic  mute_pressed;
	} item_t;

	typedef struct packed {
		level_t alarm_level;
		temp_t  avg_temp;
		logic   level2_out;
		logic   alarm_out;
		logic   beeper_on;
		logic   valve_trigger;
		logic   fault_out;
	} result_t;

endpackage

`default_nettype wire

@@ design/fire_alarm_level_controller.sv @@
// fire alarm level controller: windowed temperature mean and alarm level logic
//
// Each transfer on the item channel is one sensor tick and yields exactly one
// transfer on the result channel. The hotter of the two temperatures (or the
// fault substitute temperature during a thermistor or smoke sensor fault) is
// written into a ring of WINDOW samples; the mean over the samples written so
// far is then built by one shared adder under a small sequencer: it takes the
// item, adds up the stored samples one by one (up to WINDOW), forms the
// magnitude, runs SUM_W steps of restoring division (one quotient bit each),
// restores the sign and then settles the level and loads the output register;
// SUM_W = 12 + clog2(WINDOW+1) is the width of the sum and the quotient.
// item_stall is high while an item is worked on; a finished result waits in
// the output register, so the next item may be taken while the previous
// result is still stalled. The heat test compares the sum against threshold
// times count, so truncating the mean never changes the level. Configuration
// writes are taken at any time but belong in idle periods. The sample ring
// has no reset; only written entries are read.
`default_nettype none

module fire_alarm_level_controller #(
	parameter int WINDOW = 10
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// configuration write port
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire fal_pkg::temp_t  cfg_wdata,
	// item channel
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire fal_pkg::item_t  item,
	// result channel
	output logic                 result_valid,
	input  wire logic            result_stall,
	output fal_pkg::result_t     result
);

	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = fal_pkg::TEMP_W + CNT_W;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int PROD_W = SUM_W + 1;

	// configuration registers
	fal_pkg::temp_t thr_q;
	fal_pkg::temp_t sub_temp_q;

	// sequencer and control state
	fal_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] write_pos_q;
	logic [CNT_W-1:0] fill_q;
	fal_pkg::level_t  prev_level_q;
	logic             mute_q;
	logic             level2_q;
	logic             alarm_q;
	logic             beeper_q;
	logic             result_valid_q;

	// working registers
	fal_pkg::temp_t   ring_q [WINDOW];
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] quot_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] idx_q;
	logic [STEP_W-1:0] step_q;
	logic             smoke_q;
	logic             ext_q;
	logic             mute_press_q;
	logic             fault_q;
	fal_pkg::result_t result_q;

	// combinational signals
	logic             item_xfer;
	logic             load_result;
	fal_pkg::temp_t   t1_eff;
	fal_pkg::temp_t   t2_eff;
	fal_pkg::temp_t   sample;
	fal_pkg::temp_t   ring_rd;
	logic [CNT_W-1:0] idx_inc;
	logic [CNT_W:0]   rem_sh;
	logic [SUM_W-1:0] alu_a;
	logic [SUM_W-1:0] alu_b;
	logic             alu_cin;
	logic [SUM_W-1:0] alu_y;
	logic             trial_neg;
	logic signed [PROD_W-1:0] thr_ext;
	logic signed [PROD_W-1:0] cnt_ext;
	logic signed [PROD_W-1:0] thr_scaled;
	logic signed [PROD_W-1:0] sum_ext;
	logic             heat;
	fal_pkg::level_t  level;
	logic             mute_next;
	logic             level2_next;
	logic             alarm_next;
	logic             beeper_next;

	// handshakes: one item in flight, result parked in the output register
	assign item_stall   = (state_q != fal_pkg::ST_IDLE);
	assign item_xfer    = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// fault substitution and hotter sample
	always_comb begin
		if (item.therm_fault || item.smoke_offline) begin
			t1_eff = sub_temp_q;
			t2_eff = sub_temp_q;
		end else begin
			t1_eff = item.temp_one;
			t2_eff = item.temp_two;
		end
		sample = (t1_eff > t2_eff) ? t1_eff : t2_eff;
	end

	assign ring_rd = ring_q[idx_q[IDX_W-1:0]];
	assign idx_inc = idx_q + CNT_W'(1);
	assign rem_sh  = {rem_q, quot_q[SUM_W-1]};

	// shared adder: sum, magnitude, trial subtract and sign restore
	assign alu_y     = alu_a + alu_b + {{(SUM_W-1){1'b0}}, alu_cin};
	assign trial_neg = alu_y[SUM_W-1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fal_pkg::ST_IDLE: begin
				if (item_xfer) state_d = fal_pkg::ST_SUM;
			end
			fal_pkg::ST_SUM: begin
				if (idx_inc == fill_q) state_d = fal_pkg::ST_ABS;
			end
			fal_pkg::ST_ABS: state_d = fal_pkg::ST_DIV;
			fal_pkg::ST_DIV: begin
				if (step_q == STEP_W'(SUM_W - 1)) state_d = fal_pkg::ST_NEG;
			end
			fal_pkg::ST_NEG: state_d = fal_pkg::ST_DONE;
			fal_pkg::ST_DONE: begin
				if (load_result) state_d = fal_pkg::ST_IDLE;
			end
			default: state_d = fal_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: adder operands and result load
	always_comb begin
		alu_a       = '0;
		alu_b       = '0;
		alu_cin     = 1'b0;
		load_result = 1'b0;
		unique case (state_q)
			fal_pkg::ST_SUM: begin
				alu_a = acc_q;
				alu_b = {{(SUM_W-fal_pkg::TEMP_W){ring_rd[fal_pkg::TEMP_W-1]}}, ring_rd};
			end
			fal_pkg::ST_ABS: begin
				alu_b   = ~acc_q;
				alu_cin = 1'b1;
			end
			fal_pkg::ST_DIV: begin
				alu_a   = {{(SUM_W-CNT_W-1){1'b0}}, rem_sh};
				alu_b   = ~{{(SUM_W-CNT_W){1'b0}}, fill_q};
				alu_cin = 1'b1;
			end
			fal_pkg::ST_NEG: begin
				alu_b   = ~quot_q;
				alu_cin = 1'b1;
			end
			fal_pkg::ST_DONE: begin
				load_result = !result_valid_q || !result_stall;
			end
			default: begin
				load_result = 1'b0;
			end
		endcase
	end

	// heat test: sum >= threshold * count, exact
	assign thr_ext    = {{(PROD_W-fal_pkg::TEMP_W){thr_q[fal_pkg::TEMP_W-1]}}, thr_q};
	assign cnt_ext    = {{(PROD_W-CNT_W){1'b0}}, fill_q};
	assign thr_scaled = thr_ext * cnt_ext;
	assign sum_ext    = {acc_q[SUM_W-1], acc_q};
	assign heat       = (sum_ext >= thr_scaled);

	// level and output rules
	always_comb begin
		priority if (ext_q)         level = fal_pkg::LEVEL_FIRE;
		else if (heat && smoke_q)   level = fal_pkg::LEVEL_FIRE;
		else if (heat || smoke_q)   level = fal_pkg::LEVEL_WARN;
		else                        level = fal_pkg::LEVEL_IDLE;

		// a press sets mute, rising into level four clears it
		mute_next = mute_press_q ? 1'b1 : mute_q;
		if ((prev_level_q != fal_pkg::LEVEL_FIRE) && (level == fal_pkg::LEVEL_FIRE)) begin
			mute_next = 1'b0;
		end

		level2_next = level2_q;
		alarm_next  = alarm_q;
		beeper_next = beeper_q;
		unique case (level)
			fal_pkg::LEVEL_IDLE: level2_next = 1'b0;
			fal_pkg::LEVEL_WARN: level2_next = 1'b1;
			fal_pkg::LEVEL_FIRE: begin
				level2_next = 1'b1;
				alarm_next  = 1'b1;
				beeper_next = !mute_next;
			end
			default: level2_next = level2_q;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= fal_pkg::THRESHOLD_RESET;
			sub_temp_q <= fal_pkg::FAULT_TEMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fal_pkg::REG_THRESHOLD:  thr_q      <= cfg_wdata;
				fal_pkg::REG_FAULT_TEMP: sub_temp_q <= cfg_wdata;
				default:                 thr_q      <= thr_q;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= fal_pkg::ST_IDLE;
			write_pos_q    <= '0;
			fill_q         <= '0;
			prev_level_q   <= fal_pkg::LEVEL_IDLE;
			mute_q         <= 1'b0;
			level2_q       <= 1'b0;
			alarm_q        <= 1'b0;
			beeper_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_xfer) begin
				write_pos_q <= (write_pos_q == IDX_W'(WINDOW - 1)) ? '0
				             : write_pos_q + IDX_W'(1);
				if (fill_q != CNT_W'(WINDOW)) fill_q <= fill_q + CNT_W'(1);
			end
			if (load_result) begin
				prev_level_q <= level;
				mute_q       <= mute_next;
				level2_q     <= level2_next;
				alarm_q      <= alarm_next;
				beeper_q     <= beeper_next;
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// sample ring, no reset
	always_ff @(posedge clk) begin
		if (item_xfer) ring_q[write_pos_q] <= sample;
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			fal_pkg::ST_IDLE: begin
				if (item_xfer) begin
					acc_q        <= '0;
					idx_q        <= '0;
					smoke_q      <= item.smoke_detected && !item.smoke_offline;
					ext_q        <= item.ext_alarm_active;
					mute_press_q <= item.mute_pressed;
					fault_q      <= item.therm_fault || item.smoke_offline
					             || item.supply_fault || item.press_fault;
				end
			end
			fal_pkg::ST_SUM: begin
				acc_q <= alu_y;
				idx_q <= idx_inc;
			end
			fal_pkg::ST_ABS: begin
				quot_q <= acc_q[SUM_W-1] ? alu_y : acc_q;
				rem_q  <= '0;
				step_q <= '0;
			end
			fal_pkg::ST_DIV: begin
				// restoring step: keep the trial difference when it is not negative
				rem_q  <= trial_neg ? rem_sh[CNT_W-1:0] : alu_y[CNT_W-1:0];
				quot_q <= {quot_q[SUM_W-2:0], !trial_neg};
				step_q <= step_q + STEP_W'(1);
			end
			fal_pkg::ST_NEG: begin
				if (acc_q[SUM_W-1]) quot_q <= alu_y;
			end
			fal_pkg::ST_DONE: begin
				if (load_result) begin
					result_q.alarm_level   <= level;
					result_q.avg_temp      <= quot_q[fal_pkg::TEMP_W-1:0];
					result_q.level2_out    <= level2_next;
					result_q.alarm_out     <= alarm_next;
					result_q.beeper_on     <= beeper_next;
					result_q.valve_trigger <= (level == fal_pkg::LEVEL_FIRE);
					result_q.fault_out     <= fault_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/fal_checker.sv @@
// port checker for the fire alarm level controller, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module fal_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire fal_pkg::result_t result
);

	// one item at a time: busy right after a transfer
	`FAL_ASSERT_NEXT(a_busy_after_item, item_valid && !item_stall, item_stall)

	// only the three defined levels appear
	`FAL_ASSERT_NOW(a_level_code, result_valid, (result.alarm_level == fal_pkg::LEVEL_IDLE) || (result.alarm_level == fal_pkg::LEVEL_WARN) || (result.alarm_level == fal_pkg::LEVEL_FIRE))

	// valve pulse exactly at level four
	`FAL_ASSERT_NOW(a_valve_level, result_valid, result.valve_trigger == (result.alarm_level == fal_pkg::LEVEL_FIRE))

	// level four drives alarm and level-2
	`FAL_ASSERT_NOW(a_fire_drives, result_valid && (result.alarm_level == fal_pkg::LEVEL_FIRE), result.alarm_out && result.level2_out)

	// stalled result holds
	`FAL_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind fire_alarm_level_controller fal_checker u_fal_checker (.*);

`default_nettype wire

@@ sim/fal_checker.sv @@
// checker that predicts and compares the alarm controller results
`timescale 1ns / 100ps

module fal_scoreboard #(
	parameter int WINDOW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  fal_pkg::temp_t   cfg_wdata,
	input  logic             item_valid,
	input  logic             item_stall,
	input  fal_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  fal_pkg::result_t result,
	output int               pending,
	output int               fail_count
);

	fal_pkg::temp_t   threshold;
	fal_pkg::temp_t   fault_temp;
	int               hot_ring [WINDOW];
	int               ring_pos;
	int               ring_fill;
	fal_pkg::level_t  last_level;
	logic             muted;
	logic             level2_q;
	logic             alarm_q;
	logic             beeper_q;
	fal_pkg::result_t expected_q [$];

	// one sensor tick of the alarm controller
	function automatic fal_pkg::result_t predict_tick(fal_pkg::item_t it);
		int               temp_a;
		int               temp_b;
		int               thr;
		int               sum;
		int               i;
		logic             smoke;
		logic             heat;
		fal_pkg::level_t  level;
		fal_pkg::result_t r;
		temp_a = $signed(it.temp_one);
		temp_b = $signed(it.temp_two);
		smoke = it.smoke_detected;
		if (it.therm_fault || it.smoke_offline) begin
			temp_a = $signed(fault_temp);
			temp_b = temp_a;
		end
		if (it.smoke_offline)
			smoke = 1'b0;
		hot_ring[ring_pos] = (temp_a > temp_b) ? temp_a : temp_b;
		ring_pos = (ring_pos + 1) % WINDOW;
		if (ring_fill < WINDOW)
			ring_fill++;
		sum = 0;
		for (i = 0; i < ring_fill; i++)
			sum += hot_ring[i];
		// exact heat test, independent of the truncated mean
		thr = $signed(threshold);
		heat = (sum >= thr * ring_fill);
		if (heat && smoke)
			level = fal_pkg::LEVEL_FIRE;
		else if (heat || smoke)
			level = fal_pkg::LEVEL_WARN;
		else
			level = fal_pkg::LEVEL_IDLE;
		if (it.ext_alarm_active)
			level = fal_pkg::LEVEL_FIRE;
		if (it.mute_pressed)
			muted = 1'b1;
		if (last_level < fal_pkg::LEVEL_FIRE && level == fal_pkg::LEVEL_FIRE)
			muted = 1'b0;
		last_level = level;
		if (level == fal_pkg::LEVEL_IDLE) begin
			level2_q = 1'b0;
		end else if (level == fal_pkg::LEVEL_WARN) begin
			level2_q = 1'b1;
		end else begin
			beeper_q = !muted;
			alarm_q = 1'b1;
			level2_q = 1'b1;
		end
		r.alarm_level   = level;
		r.avg_temp      = fal_pkg::temp_t'(sum / ring_fill);
		r.level2_out    = level2_q;
		r.alarm_out     = alarm_q;
		r.beeper_on     = beeper_q;
		r.valve_trigger = (level == fal_pkg::LEVEL_FIRE);
		r.fault_out     = it.therm_fault | it.smoke_offline | it.supply_fault
		                | it.press_fault;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fal_pkg::result_t want;
		if (!arst_n) begin
			threshold = fal_pkg::THRESHOLD_RESET;
			fault_temp = fal_pkg::FAULT_TEMP_RESET;
			ring_pos = 0;
			ring_fill = 0;
			last_level = fal_pkg::LEVEL_IDLE;
			muted = 1'b0;
			level2_q = 1'b0;
			alarm_q = 1'b0;
			beeper_q = 1'b0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no result expected");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("alarm_level", want.alarm_level, result.alarm_level);
					check_field("avg_temp", $signed(want.avg_temp), $signed(result.avg_temp));
					check_field("level2_out", want.level2_out, result.level2_out);
					check_field("alarm_out", want.alarm_out, result.alarm_out);
					check_field("beeper_on", want.beeper_on, result.beeper_on);
					check_field("valve_trigger", want.valve_trigger, result.valve_trigger);
					check_field("fault_out", want.fault_out, result.fault_out);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					fal_pkg::REG_THRESHOLD:  threshold = cfg_wdata;
					fal_pkg::REG_FAULT_TEMP: fault_temp = cfg_wdata;
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				expected_q.push_back(predict_tick(item));
			pending <= expected_q.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// top of the alarm controller test: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module testbench;

	localparam int WINDOW      = 10;
	localparam int CYCLE_LIMIT = 1000000;
	// cycles to let pass after the last result
	localparam int SETTLE      = 40;
	localparam int PHASE_ITEMS = 265;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = fal_pkg::REG_THRESHOLD;
	fal_pkg::temp_t   cfg_wdata = '0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	fal_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	fal_pkg::result_t result;

	int               pending;
	int               fail_count;
	int               cycle_count = 0;
	int               burst_left = 1;
	int               stall_hold = 0;
	fal_pkg::temp_t   cur_threshold = fal_pkg::THRESHOLD_RESET;

	fire_alarm_level_controller #(.WINDOW(WINDOW)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	fal_scoreboard #(.WINDOW(WINDOW)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side back-pressure: free-running stretches, long holds and
	// cycle-by-cycle random stall, each picked at random
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					result_stall <= 1'b0;
					stall_hold = $urandom_range(20, 80);
				end
				1: begin
					result_stall <= 1'b1;
					stall_hold = $urandom_range(1, 40);
				end
				default: begin
					result_stall <= 1'($urandom_range(0, 1));
				end
			endcase
		end
	end

	function automatic fal_pkg::item_t mk(int t_one, int t_two, bit smoke, bit ntc,
	                                      bit s_fault, bit p_fault, bit pr_fault,
	                                      bit ext, bit mute);
		fal_pkg::item_t it;
		it.temp_one         = fal_pkg::temp_t'(t_one);
		it.temp_two         = fal_pkg::temp_t'(t_two);
		it.smoke_detected   = smoke;
		it.therm_fault      = ntc;
		it.smoke_offline    = s_fault;
		it.supply_fault     = p_fault;
		it.press_fault      = pr_fault;
		it.ext_alarm_active = ext;
		it.mute_pressed     = mute;
		return it;
	endfunction

	// mostly temperatures close to the threshold so the heat test flips,
	// sometimes the full 12-bit range; faults and external alarm are rarer
	function automatic fal_pkg::item_t random_tick(fal_pkg::temp_t thr);
		int t_one;
		int t_two;
		if ($urandom_range(0, 9) < 3) begin
			t_one = $urandom_range(0, 4095);
			t_two = $urandom_range(0, 4095);
		end else begin
			t_one = int'($signed(thr)) + int'($urandom_range(0, 400)) - 200;
			t_two = int'($signed(thr)) + int'($urandom_range(0, 400)) - 200;
		end
		return mk(t_one, t_two,
			$urandom_range(0, 9) < 4,
			$urandom_range(0, 11) == 0,
			$urandom_range(0, 11) == 0,
			$urandom_range(0, 9) == 0,
			$urandom_range(0, 9) == 0,
			$urandom_range(0, 9) == 0,
			$urandom_range(0, 5) == 0);
	endfunction

	// one item transfer, then maybe a gap at the end of a burst;
	// valid stays high across back-to-back transfers
	task automatic send_tick(fal_pkg::item_t it);
		int gap;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// hold off the sender until every expected result has come
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(fal_pkg::reg_idx_t idx, fal_pkg::temp_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == fal_pkg::REG_THRESHOLD)
			cur_threshold = val;
	endtask

	initial begin
		// threshold / fault temperature pairs, extremes included
		int thr_set [6]  = '{800, -2048, 2047, -400, 1500, 0};
		int ftmp_set [6] = '{300, 2047, -2048, 1500, -400, 0};
		int p;
		int n;
		int pause_at;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks on reset settings
		send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(2047, -2048, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(-2048, 2047, 1, 0, 0, 0, 0, 0, 0));
		send_tick(mk(-2048, -2048, 1, 0, 0, 0, 0, 0, 0));
		send_tick(mk(1500, -400, 0, 0, 0, 0, 0, 0, 1));
		send_tick(mk(-400, 1500, 1, 0, 0, 0, 0, 0, 0));
		send_tick(mk(-2048, -2048, 0, 0, 0, 0, 0, 0, 0));
		// mute press on the tick that rises into fire: mute is cleared
		send_tick(mk(0, 0, 0, 0, 0, 0, 0, 1, 1));
		// mute press while already at fire: beeper goes quiet
		send_tick(mk(0, 0, 0, 0, 0, 0, 0, 1, 1));
		send_tick(mk(0, 0, 0, 0, 0, 0, 0, 1, 0));
		// back to idle: level-2 drops, alarm and beeper hold
		send_tick(mk(-2048, -2048, 0, 0, 0, 0, 0, 0, 0));
		// thermistor fault replaces hot readings
		send_tick(mk(2047, 2047, 1, 1, 0, 0, 0, 0, 0));
		// smoke sensor fault also hides smoke
		send_tick(mk(2047, 2047, 1, 0, 1, 0, 0, 0, 0));
		send_tick(mk(0, 0, 0, 0, 0, 1, 0, 0, 0));
		send_tick(mk(0, 0, 0, 0, 0, 0, 1, 0, 0));
		send_tick(mk(-1, -1, 1, 1, 1, 1, 1, 1, 1));
		// more ticks past the window so the ring keeps wrapping
		for (n = 0; n < 6; n++)
			send_tick(mk(1500, 1499, 1, 0, 0, 0, 0, 0, n % 2));
		send_tick(mk(-400, -400, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(-400, -400, 0, 0, 0, 0, 0, 1, 0));

		// random phases, each on its own register setting
		for (p = 0; p < 6; p++) begin
			drain();
			if (p == 5) begin
				thr_set[p] = $urandom_range(0, 1900) - 400;
				ftmp_set[p] = $urandom_range(0, 1900) - 400;
			end
			write_reg(fal_pkg::REG_THRESHOLD, fal_pkg::temp_t'(thr_set[p]));
			write_reg(fal_pkg::REG_FAULT_TEMP, fal_pkg::temp_t'(ftmp_set[p]));
			pause_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == pause_at)
					drain();
				send_tick(random_tick(cur_threshold));
			end
		end

		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
